/* hw/rtl/ttac_pkg.sv */
// Shared types and constants for the text terminal core.
// Holds the operation codes, control byte values, parser action struct and
// the colour table. No dependencies.
package ttac_pkg;

	// Fixed field widths of the request and response beats.
	localparam int OP_W   = 2;
	localparam int BYTE_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = 16;
	localparam int NUM_W  = 16;

	typedef enum logic [OP_W-1:0] {
		OP_PUT      = 2'd0,
		OP_READ     = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_SET_ATTR = 2'd3
	} op_t;

	// Byte values that the terminal interprets.
	localparam logic [BYTE_W-1:0] BYTE_ESC      = 8'h1B;
	localparam logic [BYTE_W-1:0] BYTE_LBRACKET = 8'h5B;
	localparam logic [BYTE_W-1:0] BYTE_SGR_END  = 8'h6D;
	localparam logic [BYTE_W-1:0] BYTE_ZERO     = 8'h30;
	localparam logic [BYTE_W-1:0] BYTE_NINE     = 8'h39;
	localparam logic [BYTE_W-1:0] BYTE_LF       = 8'h0A;
	localparam logic [BYTE_W-1:0] BYTE_CR       = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_BS       = 8'h08;
	localparam logic [BYTE_W-1:0] BYTE_BLANK    = 8'h20;

	localparam logic [BYTE_W-1:0] ATTR_DEFAULT = 8'h07;
	localparam logic [NUM_W-1:0]  ESC_NUM_MAX  = 16'hFFFF;

	// What the escape parser does with the byte of a put beat.
	typedef struct packed {
		logic              consume;
		logic              attr_ld;
		logic [BYTE_W-1:0] attr_val;
	} esc_act_t;

	// Colour selection: returns {hit, attribute} for an SGR number.
	function automatic logic [BYTE_W:0] sgr_colour(input logic [NUM_W-1:0] code);
		logic [BYTE_W:0] res;
		case (code)
			16'd0:   res = {1'b1, ATTR_DEFAULT};
			16'd30:  res = {1'b1, 8'h00};
			16'd31:  res = {1'b1, 8'h04};
			16'd32:  res = {1'b1, 8'h02};
			16'd33:  res = {1'b1, 8'h0E};
			16'd34:  res = {1'b1, 8'h01};
			16'd35:  res = {1'b1, 8'h05};
			16'd36:  res = {1'b1, 8'h03};
			16'd37:  res = {1'b1, 8'h0F};
			default: res = {1'b0, 8'h00};
		endcase
		return res;
	endfunction

endpackage

/* hw/rtl/ttac_cell_ram.sv */
// Single-port-write, single-port-read cell memory with registered read data.
// Depends on ttac_pkg for the cell width.
module ttac_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [ttac_pkg::CELL_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [ttac_pkg::CELL_W-1:0] rdata
);

	logic [ttac_pkg::CELL_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/ttac_esc_parser.sv */
// ESC [ digits m colour sequence parser for the text terminal core.
// Depends on ttac_pkg for byte constants, the action struct and colour table.
module ttac_esc_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        put,
	input  logic [ttac_pkg::BYTE_W-1:0] ch,
	output ttac_pkg::esc_act_t          act
);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ESC    = 2'd1,
		PH_DIGITS = 2'd2
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic [ttac_pkg::NUM_W-1:0]   num_q, num_d;
	logic [ttac_pkg::NUM_W+3:0]   num_x10;
	logic                         is_digit;

	// Decode the byte against the current phase.
	always_comb begin
		is_digit = (ch >= ttac_pkg::BYTE_ZERO) && (ch <= ttac_pkg::BYTE_NINE);
		num_x10  = ({4'd0, num_q} << 3) + ({4'd0, num_q} << 1) + {16'd0, ch[3:0]};
		act      = '0;
		phase_d  = PH_IDLE;
		num_d    = num_q;
		case (phase_q)
			PH_ESC: begin
				if (ch == ttac_pkg::BYTE_LBRACKET) begin
					act.consume = 1'b1;
					phase_d     = PH_DIGITS;
					num_d       = '0;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					act.consume = 1'b1;
					phase_d     = PH_DIGITS;
					if (num_x10 > {4'd0, ttac_pkg::ESC_NUM_MAX}) begin
						num_d = ttac_pkg::ESC_NUM_MAX;
					end else begin
						num_d = num_x10[ttac_pkg::NUM_W-1:0];
					end
				end else if (ch == ttac_pkg::BYTE_SGR_END) begin
					act.consume                 = 1'b1;
					{act.attr_ld, act.attr_val} = ttac_pkg::sgr_colour(num_q);
				end
			end
			default: begin
				if (ch == ttac_pkg::BYTE_ESC) begin
					act.consume = 1'b1;
					phase_d     = PH_ESC;
				end
			end
		endcase
	end

	// Parser state advances only on a put beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			num_q   <= '0;
		end else if (put) begin
			phase_q <= phase_d;
			num_q   <= num_d;
		end
	end

endmodule

/* hw/rtl/text_terminal_with_ansi_color_core.sv */
// Top level of the text terminal core: cursor, attribute and sequencer.
// Depends on ttac_pkg, ttac_cell_ram and ttac_esc_parser.
//
//  channel | direction | handshake            | beat contents
//  --------+-----------+----------------------+-------------------------------------
//  request | in        | req_valid, req_ready | op, ch, color_value, row, col
//  response| out       | rsp_valid, rsp_ready | cell_data, cursor_col, cursor_row
//
// A put without scroll, a consumed escape byte, set attribute and a read outside the
// screen are answered straight from the idle state; a cell read inside the screen passes
// through ST_READ for the registered read of the cell memory.
// A put that scrolls runs the accepting step, a row-up copy through the single memory
// read port with an extra step for the last write-back, then a blank bottom row.
// Clear refills every cell with blanks in a fill pass.
// After reset a fill pass writes blanks to every cell; no request is taken.
// A request is taken only while idle and with the response register free or draining.
module text_terminal_with_ansi_color_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [ttac_pkg::OP_W-1:0]   op,
	input  logic [ttac_pkg::BYTE_W-1:0] ch,
	input  logic [ttac_pkg::BYTE_W-1:0] color_value,
	input  logic [ttac_pkg::ROW_W-1:0]  row,
	input  logic [ttac_pkg::COL_W-1:0]  col,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [ttac_pkg::CELL_W-1:0] cell_data,
	output logic [ttac_pkg::COL_W-1:0]  cursor_col,
	output logic [ttac_pkg::ROW_W-1:0]  cursor_row
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_COPY = AW'(CELLS - COLUMNS);

	typedef enum logic [2:0] {
		ST_FILL   = 3'd0,
		ST_IDLE   = 3'd1,
		ST_READ   = 3'd2,
		ST_SCROLL = 3'd3,
		ST_BLANK  = 3'd4
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                cnt_q;
	logic [AW-1:0]                wa_s1;
	logic                         wv_s1;
	logic [CW-1:0]                cur_col_q;
	logic [RW-1:0]                cur_row_q;
	logic [ttac_pkg::BYTE_W-1:0]  attr_q;
	logic                         fill_rsp_q;
	logic                         rsp_valid_q;
	logic [ttac_pkg::CELL_W-1:0]  cell_data_q;
	logic [ttac_pkg::COL_W-1:0]   rsp_col_q;
	logic [ttac_pkg::ROW_W-1:0]   rsp_row_q;

	logic                         accept;
	ttac_pkg::op_t                op_in;
	ttac_pkg::esc_act_t           act;
	logic [AW-1:0]                cur_addr;
	logic [AW-1:0]                req_addr;
	logic                         rd_in_range;
	logic [CW:0]                  col_n;
	logic [RW:0]                  row_n;
	logic                         print;
	logic                         scroll;
	logic [ttac_pkg::CELL_W-1:0]  blank;

	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [ttac_pkg::CELL_W-1:0]  mem_wdata;
	logic                         mem_re;
	logic [AW-1:0]                mem_raddr;
	logic [ttac_pkg::CELL_W-1:0]  mem_rdata;

	// Handshake and request decode.
	assign req_ready   = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept      = req_valid && req_ready;
	assign op_in       = ttac_pkg::op_t'(op);
	assign rsp_valid   = rsp_valid_q;
	assign cell_data   = cell_data_q;
	assign cursor_col  = rsp_col_q;
	assign cursor_row  = rsp_row_q;
	assign blank       = {attr_q, ttac_pkg::BYTE_BLANK};
	assign cur_addr    = AW'(cur_row_q * COLUMNS) + AW'(cur_col_q);
	assign req_addr    = AW'(row * COLUMNS) + AW'(col);
	assign rd_in_range = (row < ROWS) && (col < COLUMNS);

	ttac_esc_parser u_esc (
		.clk    (clk),
		.arst_n (arst_n),
		.put    (accept && (op_in == ttac_pkg::OP_PUT)),
		.ch     (ch),
		.act    (act)
	);

	ttac_cell_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Cursor movement for a put byte that the parser leaves alone.
	always_comb begin
		col_n = {1'b0, cur_col_q};
		row_n = {1'b0, cur_row_q};
		print = 1'b0;
		if (!act.consume) begin
			case (ch)
				ttac_pkg::BYTE_LF: begin
					col_n = '0;
					row_n = row_n + 1'b1;
				end
				ttac_pkg::BYTE_CR: begin
					col_n = '0;
				end
				ttac_pkg::BYTE_BS: begin
					if (cur_col_q != '0) begin
						col_n = col_n - 1'b1;
					end else if (cur_row_q != '0) begin
						row_n = row_n - 1'b1;
						col_n = (CW+1)'(COLUMNS - 1);
					end
				end
				default: begin
					print = 1'b1;
					col_n = col_n + 1'b1;
				end
			endcase
		end
		if (col_n >= (CW+1)'(COLUMNS)) begin
			col_n = '0;
			row_n = row_n + 1'b1;
		end
		scroll = (row_n >= (RW+1)'(ROWS));
		if (scroll) begin
			row_n = (RW+1)'(ROWS - 1);
		end
	end

	// Memory port selection per sequencer state.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = blank;
		mem_re    = 1'b0;
		mem_raddr = cnt_q + AW'(COLUMNS);
		case (state_q)
			ST_FILL, ST_BLANK: begin
				mem_we = 1'b1;
			end
			ST_SCROLL: begin
				mem_re    = (cnt_q != LAST_COPY);
				mem_we    = wv_s1;
				mem_waddr = wa_s1;
				mem_wdata = mem_rdata;
			end
			ST_IDLE: begin
				if (accept && (op_in == ttac_pkg::OP_PUT) && print) begin
					mem_we    = 1'b1;
					mem_waddr = cur_addr;
					mem_wdata = {attr_q, ch};
				end
				if (accept && (op_in == ttac_pkg::OP_READ) && rd_in_range) begin
					mem_re    = 1'b1;
					mem_raddr = req_addr;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, cursor, attribute and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			wa_s1       <= '0;
			wv_s1       <= 1'b0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			attr_q      <= ttac_pkg::ATTR_DEFAULT;
			fill_rsp_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			cell_data_q <= '0;
			rsp_col_q   <= '0;
			rsp_row_q   <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			wv_s1 <= 1'b0;
			case (state_q)
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CELL) begin
						cnt_q      <= '0;
						state_q    <= ST_IDLE;
						fill_rsp_q <= 1'b0;
						if (fill_rsp_q) begin
							rsp_valid_q <= 1'b1;
							cell_data_q <= '0;
							rsp_col_q   <= ttac_pkg::COL_W'(cur_col_q);
							rsp_row_q   <= ttac_pkg::ROW_W'(cur_row_q);
						end
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (op_in)
							ttac_pkg::OP_PUT: begin
								if (act.attr_ld) begin
									attr_q <= act.attr_val;
								end
								cur_col_q <= col_n[CW-1:0];
								cur_row_q <= row_n[RW-1:0];
								if (scroll) begin
									state_q <= ST_SCROLL;
									cnt_q   <= '0;
								end else begin
									rsp_valid_q <= 1'b1;
									cell_data_q <= '0;
									rsp_col_q   <= ttac_pkg::COL_W'(col_n[CW-1:0]);
									rsp_row_q   <= ttac_pkg::ROW_W'(row_n[RW-1:0]);
								end
							end
							ttac_pkg::OP_READ: begin
								if (rd_in_range) begin
									state_q <= ST_READ;
								end else begin
									rsp_valid_q <= 1'b1;
									cell_data_q <= '0;
									rsp_col_q   <= ttac_pkg::COL_W'(cur_col_q);
									rsp_row_q   <= ttac_pkg::ROW_W'(cur_row_q);
								end
							end
							ttac_pkg::OP_CLEAR: begin
								cur_col_q  <= '0;
								cur_row_q  <= '0;
								cnt_q      <= '0;
								fill_rsp_q <= 1'b1;
								state_q    <= ST_FILL;
							end
							default: begin
								attr_q      <= color_value;
								rsp_valid_q <= 1'b1;
								cell_data_q <= '0;
								rsp_col_q   <= ttac_pkg::COL_W'(cur_col_q);
								rsp_row_q   <= ttac_pkg::ROW_W'(cur_row_q);
							end
						endcase
					end
				end
				ST_READ: begin
					state_q     <= ST_IDLE;
					rsp_valid_q <= 1'b1;
					cell_data_q <= mem_rdata;
					rsp_col_q   <= ttac_pkg::COL_W'(cur_col_q);
					rsp_row_q   <= ttac_pkg::ROW_W'(cur_row_q);
				end
				ST_SCROLL: begin
					// Read row below at cnt + COLUMNS, write it back at cnt in the following cycle.
					wv_s1 <= (cnt_q != LAST_COPY);
					wa_s1 <= cnt_q;
					if (cnt_q == LAST_COPY) begin
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_BLANK: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q       <= '0;
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						cell_data_q <= '0;
						rsp_col_q   <= ttac_pkg::COL_W'(cur_col_q);
						rsp_row_q   <= ttac_pkg::ROW_W'(cur_row_q);
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/tb_top.sv */
// Self-checking bench for the text terminal core: a request driver with bursty
// pacing, a response monitor that predicts every beat, and a stalling receiver.
// Depends on ttac_pkg and text_terminal_with_ansi_color_core.
module tb_top;

	localparam int COLS   = 80;
	localparam int ROWS_N = 25;
	localparam int CELLS  = COLS * ROWS_N;
	localparam int N_RAND = 650;
	localparam int LIMIT  = 6_000_000;
	localparam int TAIL   = 64;

	// Foreground colours selected by SGR numbers 30 to 37.
	localparam logic [ttac_pkg::BYTE_W-1:0] SGR_FG [0:7] = '{
		8'h00, 8'h04, 8'h02, 8'h0E, 8'h01, 8'h05, 8'h03, 8'h0F
	};

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEEN_ESC,
		PH_DIGITS
	} esc_phase_t;

	typedef struct packed {
		ttac_pkg::op_t               op;
		logic [ttac_pkg::BYTE_W-1:0] ch;
		logic [ttac_pkg::BYTE_W-1:0] cv;
		logic [ttac_pkg::ROW_W-1:0]  row;
		logic [ttac_pkg::COL_W-1:0]  col;
		logic                        hold;
	} term_req_t;

	typedef struct packed {
		logic [ttac_pkg::CELL_W-1:0] cdata;
		logic [ttac_pkg::COL_W-1:0]  ccol;
		logic [ttac_pkg::ROW_W-1:0]  crow;
	} term_rsp_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        req_valid = 1'b0;
	logic                        req_ready;
	logic [ttac_pkg::OP_W-1:0]   op = '0;
	logic [ttac_pkg::BYTE_W-1:0] ch = '0;
	logic [ttac_pkg::BYTE_W-1:0] color_value = '0;
	logic [ttac_pkg::ROW_W-1:0]  row = '0;
	logic [ttac_pkg::COL_W-1:0]  col = '0;
	logic                        rsp_valid;
	logic                        rsp_ready = 1'b0;
	logic [ttac_pkg::CELL_W-1:0] cell_data;
	logic [ttac_pkg::COL_W-1:0]  cursor_col;
	logic [ttac_pkg::ROW_W-1:0]  cursor_row;

	// Screen image and terminal state as the core should hold them.
	logic [ttac_pkg::CELL_W-1:0] screen_img [0:CELLS-1];
	int                          cur_c;
	int                          cur_r;
	logic [ttac_pkg::BYTE_W-1:0] attr_now;
	esc_phase_t                  esc_ph;
	int unsigned                 esc_num;

	term_req_t pending_q [$];
	term_rsp_t screen_rsp_q [$];
	int        n_req = 0;
	int        n_rsp = 0;
	int        n_err = 0;
	int        n_queued = 0;
	bit        hold_next = 1'b0;
	int        cycle_cnt = 0;

	// Driver pacing state.
	int        burst_left = 0;
	int        gap_left = 0;
	bit        drive_next;
	term_req_t nxt;

	// Receiver stall pattern.
	logic [15:0] stall_pat = 16'hFFFF;
	int          stall_mode = 0;
	int          stall_idx = 0;

	text_terminal_with_ansi_color_core #(
		.COLUMNS(COLS),
		.ROWS   (ROWS_N)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.op         (op),
		.ch         (ch),
		.color_value(color_value),
		.row        (row),
		.col        (col),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.cell_data  (cell_data),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row)
	);

	always #6 clk = ~clk;

	// Works out the response to one request and updates the terminal state.
	function automatic term_rsp_t terminal_predict(term_req_t rq);
		term_rsp_t                   rs;
		logic [ttac_pkg::BYTE_W-1:0] c;
		bit                          shown;
		int unsigned                 n;
		rs.cdata = '0;
		c = rq.ch;
		case (rq.op)
			ttac_pkg::OP_PUT: begin
				shown = 1'b1;
				// Escape parser: ESC, then '[', then digits, ended by 'm'.
				if (esc_ph == PH_SEEN_ESC) begin
					if (c == ttac_pkg::BYTE_LBRACKET) begin
						esc_ph = PH_DIGITS;
						esc_num = 0;
						shown = 1'b0;
					end else begin
						esc_ph = PH_IDLE;
					end
				end else if (esc_ph == PH_DIGITS) begin
					if (c >= ttac_pkg::BYTE_ZERO && c <= ttac_pkg::BYTE_NINE) begin
						n = esc_num * 10 + (c - ttac_pkg::BYTE_ZERO);
						esc_num = (n > ttac_pkg::ESC_NUM_MAX) ? ttac_pkg::ESC_NUM_MAX : n;
						shown = 1'b0;
					end else if (c == ttac_pkg::BYTE_SGR_END) begin
						if (esc_num == 0)
							attr_now = ttac_pkg::ATTR_DEFAULT;
						else if (esc_num >= 30 && esc_num <= 37)
							attr_now = SGR_FG[esc_num-30];
						esc_ph = PH_IDLE;
						shown = 1'b0;
					end else begin
						esc_ph = PH_IDLE;
					end
				end else if (c == ttac_pkg::BYTE_ESC) begin
					esc_ph = PH_SEEN_ESC;
					shown = 1'b0;
				end
				// Bytes the parser let through: controls or printing.
				if (shown) begin
					if (c == ttac_pkg::BYTE_LF) begin
						cur_c = 0;
						cur_r++;
					end else if (c == ttac_pkg::BYTE_CR) begin
						cur_c = 0;
					end else if (c == ttac_pkg::BYTE_BS) begin
						if (cur_c > 0) begin
							cur_c--;
						end else if (cur_r > 0) begin
							cur_r--;
							cur_c = COLS - 1;
						end
					end else begin
						screen_img[cur_r*COLS+cur_c] = {attr_now, c};
						cur_c++;
					end
					if (cur_c >= COLS) begin
						cur_c = 0;
						cur_r++;
					end
					if (cur_r >= ROWS_N) begin
						for (int i = 0; i < CELLS - COLS; i++)
							screen_img[i] = screen_img[i+COLS];
						for (int i = CELLS - COLS; i < CELLS; i++)
							screen_img[i] = {attr_now, ttac_pkg::BYTE_BLANK};
						cur_r = ROWS_N - 1;
					end
				end
			end
			ttac_pkg::OP_READ: begin
				if (rq.row < ROWS_N && rq.col < COLS)
					rs.cdata = screen_img[rq.row*COLS+rq.col];
			end
			ttac_pkg::OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_img[i] = {attr_now, ttac_pkg::BYTE_BLANK};
				cur_c = 0;
				cur_r = 0;
			end
			default: begin
				attr_now = rq.cv;
			end
		endcase
		rs.ccol = cur_c[ttac_pkg::COL_W-1:0];
		rs.crow = cur_r[ttac_pkg::ROW_W-1:0];
		return rs;
	endfunction

	task automatic report(string what, int got, int want);
		n_err++;
		if (n_err <= 40)
			$display("tb_top: %s got %0h expected %0h at response %0d", what, got, want, n_rsp);
	endtask

	// Request builders; fields that the operation ignores carry random values.
	task automatic queue_item(ttac_pkg::op_t o, logic [ttac_pkg::BYTE_W-1:0] c,
			logic [ttac_pkg::BYTE_W-1:0] v, logic [ttac_pkg::ROW_W-1:0] r,
			logic [ttac_pkg::COL_W-1:0] cl);
		term_req_t it;
		it.op = o;
		it.ch = c;
		it.cv = v;
		it.row = r;
		it.col = cl;
		it.hold = hold_next;
		hold_next = 1'b0;
		pending_q.push_back(it);
		n_queued++;
	endtask

	task automatic put_char(logic [ttac_pkg::BYTE_W-1:0] c);
		queue_item(ttac_pkg::OP_PUT, c, 8'($urandom_range(0, 255)),
			5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
	endtask

	task automatic read_cell(int r, int cl);
		queue_item(ttac_pkg::OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			5'(r), 7'(cl));
	endtask

	task automatic set_attr(logic [ttac_pkg::BYTE_W-1:0] v);
		queue_item(ttac_pkg::OP_SET_ATTR, 8'($urandom_range(0, 255)), v,
			5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
	endtask

	task automatic clear_screen();
		queue_item(ttac_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
	endtask

	task automatic send_sgr(string digits);
		put_char(ttac_pkg::BYTE_ESC);
		put_char(ttac_pkg::BYTE_LBRACKET);
		for (int i = 0; i < digits.len(); i++)
			put_char(digits[i]);
		put_char(ttac_pkg::BYTE_SGR_END);
	endtask

	// Random traffic: mostly text and well-formed colour sequences, some noise.
	task automatic random_traffic();
		int          sel;
		int          len;
		int unsigned num;
		string       digits;
		logic [7:0]  b;
		int          n_dir;
		bit          mid_hold;
		n_dir = n_queued;
		mid_hold = 1'b0;
		while (n_queued < n_dir + N_RAND) begin
			if (!mid_hold && n_queued >= n_dir + N_RAND / 2) begin
				hold_next = 1'b1;
				mid_hold = 1'b1;
			end
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				len = $urandom_range(1, 24);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) < 7)
						put_char(8'($urandom_range(32, 126)));
					else
						put_char(8'($urandom_range(0, 255)));
				end
			end else if (sel < 52) begin
				len = $urandom_range(0, 9);
				if (len < 5)
					num = $urandom_range(30, 37);
				else if (len < 6)
					num = 0;
				else if (len < 8)
					num = $urandom_range(0, 999);
				else
					num = $urandom;
				digits = $sformatf("%0d", num);
				if ($urandom_range(0, 9) == 0)
					digits = {"0", digits};
				if (len == 9 && $urandom_range(0, 1) == 0)
					digits = "";
				send_sgr(digits);
			end else if (sel < 57) begin
				put_char(ttac_pkg::BYTE_ESC);
				if ($urandom_range(0, 1) == 0) begin
					do b = 8'($urandom_range(0, 255)); while (b == ttac_pkg::BYTE_LBRACKET);
					put_char(b);
				end else begin
					put_char(ttac_pkg::BYTE_LBRACKET);
					len = $urandom_range(0, 3);
					for (int i = 0; i < len; i++)
						put_char(8'(ttac_pkg::BYTE_ZERO + $urandom_range(0, 9)));
					do b = 8'($urandom_range(0, 255));
					while ((b >= ttac_pkg::BYTE_ZERO && b <= ttac_pkg::BYTE_NINE) ||
						b == ttac_pkg::BYTE_SGR_END);
					put_char(b);
				end
			end else if (sel < 69) begin
				len = $urandom_range(0, 9);
				put_char(len < 5 ? ttac_pkg::BYTE_LF :
					(len < 7 ? ttac_pkg::BYTE_CR : ttac_pkg::BYTE_BS));
			end else if (sel < 86) begin
				if ($urandom_range(0, 6) == 0)
					read_cell($urandom_range(0, 31), $urandom_range(0, 127));
				else
					read_cell($urandom_range(0, ROWS_N - 1), $urandom_range(0, COLS - 1));
			end else if (sel < 96) begin
				set_attr(8'($urandom_range(0, 255)));
			end else if (sel < 99) begin
				clear_screen();
			end else begin
				read_cell(ROWS_N - 1, $urandom_range(0, COLS - 1));
			end
		end
	endtask

	// Request driver: presents queued beats in bursts separated by gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!req_valid || req_ready) begin
			drive_next = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_q.size() != 0 &&
					(!pending_q[0].hold || (!req_valid && n_req == n_rsp))) begin
				nxt = pending_q.pop_front();
				op <= nxt.op;
				ch <= nxt.ch;
				color_value <= nxt.cv;
				row <= nxt.row;
				col <= nxt.col;
				drive_next = 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					if ($urandom_range(0, 4) == 0) begin
						burst_left = $urandom_range(30, 90);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 10);
						gap_left = $urandom_range(1, 7);
					end
				end
			end
			req_valid <= drive_next;
		end
	end

	// Receiver: ready steps through a 16-bit stall pattern, redrawn periodically.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_idx = 0;
		end else begin
			if (stall_idx % 64 == 0) begin
				stall_mode = $urandom_range(0, 3);
				case (stall_mode)
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'($urandom | $urandom);
					3: stall_pat = 16'($urandom & $urandom);
					default: stall_pat = 16'hFFFF;
				endcase
				stall_pat[$urandom_range(0, 15)] = 1'b1;
			end
			rsp_ready <= stall_pat[stall_idx % 16];
			stall_idx++;
		end
	end

	// Monitor: checks response beats, then predicts accepted request beats.
	always @(posedge clk or negedge arst_n) begin
		term_rsp_t want;
		term_req_t rq;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen_img[i] = {ttac_pkg::ATTR_DEFAULT, ttac_pkg::BYTE_BLANK};
			cur_c = 0;
			cur_r = 0;
			attr_now = ttac_pkg::ATTR_DEFAULT;
			esc_ph = PH_IDLE;
			esc_num = 0;
			screen_rsp_q.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (screen_rsp_q.size() == 0) begin
					report("response with none outstanding, cell_data", cell_data, 0);
				end else begin
					want = screen_rsp_q.pop_front();
					if (cell_data !== want.cdata)
						report("cell_data", cell_data, want.cdata);
					if (cursor_col !== want.ccol)
						report("cursor_col", cursor_col, want.ccol);
					if (cursor_row !== want.crow)
						report("cursor_row", cursor_row, want.crow);
				end
				n_rsp <= n_rsp + 1;
			end
			if (req_valid && req_ready) begin
				rq.op = ttac_pkg::op_t'(op);
				rq.ch = ch;
				rq.cv = color_value;
				rq.row = row;
				rq.col = col;
				rq.hold = 1'b0;
				screen_rsp_q.push_back(terminal_predict(rq));
				n_req <= n_req + 1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		// Directed opening: reset contents, edges of the read range, wide bytes,
		// colour sequences, a printed ESC, controls at the edges and a wrap.
		read_cell(0, 0);
		read_cell(31, 127);
		put_char(ttac_pkg::BYTE_BS);
		put_char(8'h41);
		put_char(8'hFF);
		set_attr(8'h00);
		put_char(8'h80);
		send_sgr("33");
		put_char(8'h00);
		put_char(ttac_pkg::BYTE_ESC);
		put_char(ttac_pkg::BYTE_ESC);
		send_sgr("");
		put_char(ttac_pkg::BYTE_CR);
		put_char(ttac_pkg::BYTE_LF);
		put_char(ttac_pkg::BYTE_BS);
		put_char(8'h5A);
		read_cell(0, COLS - 1);
		set_attr(8'hFF);
		clear_screen();
		read_cell(ROWS_N - 1, COLS - 1);
		hold_next = 1'b1;
		random_traffic();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (pending_q.size() != 0 || req_valid || n_rsp != n_req);
		repeat (TAIL) @(negedge clk);
		if (screen_rsp_q.size() != 0)
			report("responses still outstanding", screen_rsp_q.size(), 0);
		if (n_err == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
